@@ rtl/core/phsq_pkg.sv @@
// Package for the prefix hash substring query block.
// Request codes, status codes, field widths and store size; no dependencies.
`default_nettype none
package phsq_pkg;
  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned POS_W = 11;
  localparam int unsigned END_W = 10;
  localparam int unsigned HASH_W = 64;
  localparam int unsigned BASE_W = 16;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ADDR_W = $clog2(MAX_LEN + 1);

  localparam logic [BASE_W-1:0] BASE_RESET = 16'd131;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_HASH   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LCP    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CMP    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

@@ rtl/core/phsq_if.sv @@
// Channel interfaces of the prefix hash substring query block.
// Depends on phsq_pkg for field widths.
`default_nettype none
interface phsq_req_if;
  logic valid;
  logic ready;
  logic [phsq_pkg::REQ_W-1:0] req_type;
  logic [phsq_pkg::CHAR_W-1:0] char_in;
  logic [phsq_pkg::POS_W-1:0] start_first;
  logic [phsq_pkg::END_W-1:0] end_first;
  logic [phsq_pkg::POS_W-1:0] start_second;
  logic [phsq_pkg::END_W-1:0] end_second;
  modport source(output valid, req_type, char_in, start_first, end_first, start_second,
                 end_second, input ready);
  modport sink(input valid, req_type, char_in, start_first, end_first, start_second,
               end_second, output ready);
endinterface

interface phsq_rsp_if;
  logic valid;
  logic ready;
  logic [phsq_pkg::STAT_W-1:0] status;
  logic [phsq_pkg::HASH_W-1:0] hash_value;
  logic [phsq_pkg::POS_W-1:0] prefix_length;
  logic is_less;
  logic [phsq_pkg::POS_W-1:0] stored_length;
  modport source(output valid, status, hash_value, prefix_length, is_less, stored_length,
                 input ready);
  modport sink(input valid, status, hash_value, prefix_length, is_less, stored_length,
               output ready);
endinterface

interface phsq_cfg_if;
  logic valid;
  logic ready;
  logic [phsq_pkg::BASE_W-1:0] hash_base;
  modport source(output valid, hash_base, input ready);
  modport sink(input valid, hash_base, output ready);
endinterface
`default_nettype wire

@@ rtl/core/phsq_mul.sv @@
// Iterative 64x64 multiplier keeping the low 64 bits, one 32x32 product a cycle.
// Depends on phsq_pkg.
`default_nettype none
module phsq_mul (
  input  logic clk_i,
  input  logic rst_ni,
  input  phsq_pkg::mul_req_t req_i,
  output logic done_o,
  output logic [phsq_pkg::HASH_W-1:0] prod_o
);
  import phsq_pkg::*;

  logic [HASH_W-1:0] a_q, b_q, m_q, acc_q;
  logic [1:0] step_q;
  logic busy_q, done_q;
  logic [31:0] x, y;
  logic [HASH_W-1:0] pp;

  // low x low, then the two cross terms that land in the upper half
  always_comb begin
    case (step_q)
      2'd0: begin x = a_q[31:0]; y = b_q[31:0]; end
      2'd1: begin x = a_q[31:0]; y = b_q[63:32]; end
      2'd2: begin x = a_q[63:32]; y = b_q[31:0]; end
      default: begin x = a_q[31:0]; y = b_q[31:0]; end
    endcase
  end

  assign pp = HASH_W'(x) * HASH_W'(y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= !req_i.start && busy_q && (step_q == 2'd3);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      m_q <= pp;
      if (step_q == 2'd1) begin
        acc_q <= m_q;
      end else if (step_q != 2'd0) begin
        acc_q <= acc_q + {m_q[31:0], 32'd0};
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

@@ rtl/core/phsq_tables.sv @@
// Prefix hash and base power memories with registered reads.
// Entry zero of each is a constant; depends on phsq_pkg.
`default_nettype none
module phsq_tables (
  input  logic clk_i,
  input  logic we_i,
  input  logic [phsq_pkg::ADDR_W-1:0] waddr_i,
  input  logic [phsq_pkg::HASH_W-1:0] wprefix_i,
  input  logic [phsq_pkg::HASH_W-1:0] wpower_i,
  input  logic [phsq_pkg::ADDR_W-1:0] ra_i,
  input  logic [phsq_pkg::ADDR_W-1:0] rb_i,
  input  logic [phsq_pkg::ADDR_W-1:0] rc_i,
  output logic [phsq_pkg::HASH_W-1:0] pa_o,
  output logic [phsq_pkg::HASH_W-1:0] pb_o,
  output logic [phsq_pkg::HASH_W-1:0] pw_o
);
  import phsq_pkg::*;

  logic [HASH_W-1:0] prefix_mem [0:MAX_LEN];
  logic [HASH_W-1:0] power_mem [0:MAX_LEN];
  logic [HASH_W-1:0] pa_q, pb_q, pw_q;
  logic za_q, zb_q, zc_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      prefix_mem[waddr_i] <= wprefix_i;
      power_mem[waddr_i] <= wpower_i;
    end
    pa_q <= prefix_mem[ra_i];
    pb_q <= prefix_mem[rb_i];
    pw_q <= power_mem[rc_i];
    za_q <= (ra_i == '0);
    zb_q <= (rb_i == '0);
    zc_q <= (rc_i == '0);
  end

  // entry zero: empty prefix hashes to 0, base to the power 0 is 1
  assign pa_o = za_q ? '0 : pa_q;
  assign pb_o = zb_q ? '0 : pb_q;
  assign pw_o = zc_q ? HASH_W'(1) : pw_q;
endmodule
`default_nettype wire

@@ rtl/core/prefix_hash_substring_query.sv @@
// Prefix hash substring query: one request beat in, one result beat out.
// A common prefix or compare runs a binary search of up to 11 probes, and a
// compare may then check the first differing byte. Each span hash is a table
// read and one 64-bit multiply on the shared 32x32 multiplier. One request at a
// time.
// Reset (async, active low) empties the string and sets the base to 131.
`default_nettype none
module prefix_hash_substring_query (
  input  logic clk_i,
  input  logic rst_ni,
  phsq_req_if.sink   req_i,
  phsq_rsp_if.source rsp_o,
  phsq_cfg_if.sink   cfg_i
);
  import phsq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q;
  logic [REQ_W-1:0] op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [POS_W-1:0] l1_q, l2_q, len_q, lo_q, hi_q, mid_q, pos_q, slen_q, len1_q, len2_q;
  logic [END_W-1:0] r1_q, r2_q;
  logic [BASE_W-1:0] base_q;
  logic which_q, tail_q;
  logic [HASH_W-1:0] h1_q, pa_q, pw_q;

  // result being built, and the output register
  logic [STAT_W-1:0] res_st_q, out_st_q;
  logic [HASH_W-1:0] res_hv_q, out_hv_q;
  logic [POS_W-1:0] res_pl_q, out_pl_q, out_len_q;
  logic res_less_q, out_less_q, out_vld_q;

  logic [HASH_W-1:0] rd_pa, rd_pb, rd_pw, mul_prod, span_h;
  logic mul_done, tbl_we;
  mul_req_t mul_req;

  logic accept;
  logic ok1, ok2;
  logic [POS_W-1:0] rlen1, rlen2, maxl, shorter;
  logic [POS_W:0] mid_sum;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // range checks on the latched request
  assign ok1 = (l1_q <= POS_W'(r1_q)) && (POS_W'(r1_q) < len_q);
  assign ok2 = (l2_q <= POS_W'(r2_q)) && (POS_W'(r2_q) < len_q);
  assign rlen1 = POS_W'(r1_q) - l1_q + POS_W'(1);
  assign rlen2 = POS_W'(r2_q) - l2_q + POS_W'(1);
  assign maxl = (l1_q > l2_q) ? l1_q : l2_q;
  assign shorter = (len1_q < len2_q) ? len1_q : len2_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (POS_W+1)'(1);

  assign span_h = pa_q - mul_prod;

  // append: write both tables once the power product is back
  assign tbl_we = (state_q == S_WAIT) && mul_done && (op_q == REQ_APPEND) && which_q;

  phsq_tables u_tables (
    .clk_i    (clk_i),
    .we_i     (tbl_we),
    .waddr_i  (ADDR_W'(len_q + POS_W'(1))),
    .wprefix_i(h1_q),
    .wpower_i (mul_prod),
    .ra_i     (ADDR_W'(pos_q + slen_q)),
    .rb_i     (ADDR_W'(pos_q)),
    .rc_i     (ADDR_W'((op_q == REQ_APPEND) ? pos_q : slen_q)),
    .pa_o     (rd_pa),
    .pb_o     (rd_pb),
    .pw_o     (rd_pw)
  );

  // multiplier start: prefix[pos] times power[len]; on append, prefix[len] and then power[len] times the base
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a = rd_pb;
    mul_req.b = (op_q == REQ_APPEND) ? HASH_W'(base_q) : rd_pw;
    if (state_q == S_MUL) begin
      mul_req.start = 1'b1;
    end else if (state_q == S_WAIT && mul_done && op_q == REQ_APPEND && !which_q) begin
      mul_req.start = 1'b1;
      mul_req.a = pw_q;
    end
  end

  phsq_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .done_o(mul_done),
    .prod_o(mul_prod)
  );

  // configuration: base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      base_q <= cfg_i.hash_base;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it this cycle
      if (rsp_o.ready && state_q != S_FIN) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          case (op_q)
            REQ_CLEAR: begin
              len_q <= '0;
              state_q <= S_FIN;
            end
            REQ_APPEND: begin
              state_q <= (len_q >= POS_W'(MAX_LEN)) ? S_FIN : S_READ;
            end
            REQ_HASH: begin
              state_q <= ok1 ? S_READ : S_FIN;
            end
            REQ_LCP: begin
              state_q <= (l1_q <= len_q && l2_q <= len_q) ? S_PROBE : S_FIN;
            end
            REQ_CMP: begin
              state_q <= (ok1 && ok2) ? S_PROBE : S_FIN;
            end
            default: begin
              state_q <= S_FIN;
            end
          endcase
        end
        S_PROBE: begin
          if (lo_q < hi_q) begin
            state_q <= S_READ;
          end else if (op_q == REQ_CMP && lo_q < shorter) begin
            state_q <= S_READ;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_READ: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            if (op_q == REQ_APPEND) begin
              if (which_q) begin
                len_q <= len_q + POS_W'(1);
                state_q <= S_FIN;
              end
            end else if (!which_q) begin
              state_q <= (op_q == REQ_HASH) ? S_FIN : S_READ;
            end else begin
              state_q <= tail_q ? S_FIN : S_PROBE;
            end
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q <= req_i.req_type;
          ch_q <= req_i.char_in;
          l1_q <= req_i.start_first;
          r1_q <= req_i.end_first;
          l2_q <= req_i.start_second;
          r2_q <= req_i.end_second;
          res_st_q <= ST_OK;
          res_hv_q <= '0;
          res_pl_q <= '0;
          res_less_q <= 1'b0;
        end
      end
      S_DISP: begin
        which_q <= 1'b0;
        tail_q <= 1'b0;
        lo_q <= '0;
        hi_q <= len_q - maxl;
        len1_q <= rlen1;
        len2_q <= rlen2;
        case (op_q)
          REQ_APPEND: begin
            if (len_q >= POS_W'(MAX_LEN)) begin
              res_st_q <= ST_FULL;
            end
            pos_q <= len_q;
            slen_q <= '0;
          end
          REQ_HASH: begin
            if (!ok1) begin
              res_st_q <= ST_RANGE;
            end
            pos_q <= l1_q;
            slen_q <= rlen1;
          end
          REQ_LCP: begin
            if (!(l1_q <= len_q && l2_q <= len_q)) begin
              res_st_q <= ST_RANGE;
            end
          end
          REQ_CMP: begin
            if (!(ok1 && ok2)) begin
              res_st_q <= ST_RANGE;
            end
          end
          default: begin
            pos_q <= '0;
          end
        endcase
      end
      S_PROBE: begin
        which_q <= 1'b0;
        if (lo_q < hi_q) begin
          mid_q <= mid_sum[POS_W:1];
          pos_q <= l1_q;
          slen_q <= mid_sum[POS_W:1];
        end else if (op_q == REQ_CMP) begin
          if (lo_q >= shorter) begin
            res_pl_q <= shorter;
            res_less_q <= (len1_q < len2_q);
          end else begin
            // first differing byte decides the order
            res_pl_q <= lo_q;
            tail_q <= 1'b1;
            pos_q <= l1_q + lo_q;
            slen_q <= POS_W'(1);
          end
        end else begin
          res_pl_q <= lo_q;
        end
      end
      S_MUL: begin
        pa_q <= rd_pa;
        pw_q <= rd_pw;
      end
      S_WAIT: begin
        if (mul_done) begin
          which_q <= !which_q;
          if (op_q == REQ_APPEND) begin
            if (!which_q) begin
              h1_q <= mul_prod + HASH_W'(ch_q);
            end
          end else if (!which_q) begin
            h1_q <= span_h;
            res_hv_q <= (op_q == REQ_HASH) ? span_h : '0;
            pos_q <= tail_q ? (l2_q + lo_q) : l2_q;
          end else if (tail_q) begin
            res_less_q <= (h1_q < span_h);
          end else if (h1_q == span_h) begin
            lo_q <= mid_q;
          end else begin
            hi_q <= mid_q - POS_W'(1);
          end
        end
      end
      default: begin
        which_q <= which_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && (!out_vld_q || rsp_o.ready)) begin
      out_st_q <= res_st_q;
      out_hv_q <= res_hv_q;
      out_pl_q <= res_pl_q;
      out_less_q <= res_less_q;
      out_len_q <= len_q;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.status = out_st_q;
  assign rsp_o.hash_value = out_hv_q;
  assign rsp_o.prefix_length = out_pl_q;
  assign rsp_o.is_less = out_less_q;
  assign rsp_o.stored_length = out_len_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= POS_W'(MAX_LEN))
    else $error("stored length beyond capacity");
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> len_q < POS_W'(MAX_LEN))
    else $error("table write on a full store");
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_WAIT)
    else $error("multiplier result outside wait state");
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISP)
    else $error("accepted beat not dispatched");
`endif
endmodule
`default_nettype wire
